[src/sdht_pkg.sv]
// Package for the seen-device hit table: result codes, sequencer states,
// table entry layout and the saturating increment.
// No dependencies.
package sdht_pkg;

  localparam int unsigned CHANNEL_W = 7;
  localparam int unsigned PREFIX_W  = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned INDEX_W   = 4;

  // Prefixes that cannot come from a real device
  localparam logic [PREFIX_W-1:0] PREFIX_ZEROS = {PREFIX_W{1'b0}};
  localparam logic [PREFIX_W-1:0] PREFIX_ONES  = {PREFIX_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OUT_REJECT = 2'd0,
    OUT_MATCH  = 2'd1,
    OUT_INSERT = 2'd2,
    OUT_DROP   = 2'd3
  } outcome_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CMP  = 1'b1
  } state_e;

  // One stored table entry
  typedef struct packed {
    logic [PREFIX_W-1:0]  key;
    logic [CHANNEL_W-1:0] channel;
    logic [TIME_W-1:0]    last_seen;
    logic [COUNT_W-1:0]   hits;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

[src/sdht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sdht_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/seen_device_hit_table_unit.sv]
// Seen-device hit table top level: sequencer, shared key comparator,
// entry RAM and result register. Depends on sdht_pkg and sdht_ram.
// Lookup: a rejected prefix or an empty table is answered from the idle state;
//   otherwise the single key comparator steps one RAM read per cycle through
//   the used entries until a hit or the last used entry.
// Input: a new packet is taken only in the idle state, once the result
//   register is empty or being drained; none is taken during a scan.
// Reset: asynchronous active low; clears fill count, total and control state.
//   Entry RAM contents are not cleared; only entries below the fill count are compared.
module seen_device_hit_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // channel[6:0], packet_prefix[54:7], time_ms[86:55]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // outcome[1:0], entry_index[5:2],
                                     // entry_count[37:6], total_hits[69:38]
);
  import sdht_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  // input fields
  logic [CHANNEL_W-1:0] s_channel;
  logic [PREFIX_W-1:0]  s_prefix;
  logic [TIME_W-1:0]    s_time;
  assign s_channel = s_axis_tdata[6:0];
  assign s_prefix  = s_axis_tdata[54:7];
  assign s_time    = s_axis_tdata[86:55];

  state_e state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [COUNT_W-1:0]   total_q, total_d;
  logic [CHANNEL_W-1:0] ch_q;
  logic [PREFIX_W-1:0]  key_q;
  logic [TIME_W-1:0]    time_q;

  logic s_accept;
  logic plausible;
  logic key_hit;
  logic scan_last;
  logic [CNT_W-1:0] idx_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  logic           do_insert;
  logic           res_load;
  outcome_e       res_outcome;
  logic [IDX_W-1:0] res_index;
  logic [COUNT_W-1:0] res_count;

  logic               out_valid_q;
  outcome_e           out_outcome_q;
  logic [INDEX_W-1:0] out_index_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [COUNT_W-1:0] out_total_q;
  logic [IDX_W+INDEX_W-1:0] res_index_ext;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign plausible     = (s_prefix != PREFIX_ZEROS) && (s_prefix != PREFIX_ONES);

  // shared comparator and scan bookkeeping
  assign key_hit   = (ram_rdata.key == key_q);
  assign idx_next  = {1'b0, idx_q} + CNT_W'(1);
  assign scan_last = (idx_next >= used_q);
  assign ram_raddr = (state_q == ST_IDLE) ? '0 : idx_next[IDX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && plausible && (used_q != '0)) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (key_hit || scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = used_q[IDX_W-1:0];
    ram_wdata   = '{key: key_q, channel: ch_q, last_seen: time_q, hits: COUNT_W'(1)};
    do_insert   = 1'b0;
    res_load    = 1'b0;
    res_outcome = OUT_REJECT;
    res_index   = '0;
    res_count   = '0;
    used_d      = used_q;
    total_d     = total_q;
    idx_d       = idx_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (s_accept) begin
          ram_wdata = '{key: s_prefix, channel: s_channel, last_seen: s_time,
                        hits: COUNT_W'(1)};
          if (!plausible) begin
            res_load = 1'b1;
          end else if (used_q == '0) begin
            do_insert = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (key_hit) begin
          ram_we      = 1'b1;
          ram_waddr   = idx_q;
          ram_wdata   = '{key: ram_rdata.key, channel: ch_q, last_seen: time_q,
                          hits: sat_inc(ram_rdata.hits)};
          res_load    = 1'b1;
          res_outcome = OUT_MATCH;
          res_index   = idx_q;
          res_count   = sat_inc(ram_rdata.hits);
          total_d     = sat_inc(total_q);
        end else if (scan_last) begin
          if (used_q == CNT_W'(ENTRIES)) begin
            res_load    = 1'b1;
            res_outcome = OUT_DROP;
          end else begin
            do_insert = 1'b1;
          end
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      default: ;
    endcase
    // append a new entry at the fill point
    if (do_insert) begin
      ram_we      = 1'b1;
      res_load    = 1'b1;
      res_outcome = OUT_INSERT;
      res_index   = used_q[IDX_W-1:0];
      res_count   = COUNT_W'(1);
      used_d      = used_q + CNT_W'(1);
      total_d     = sat_inc(total_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      used_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
      total_q <= total_d;
    end
  end

  // captured packet fields
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ch_q   <= s_channel;
      key_q  <= s_prefix;
      time_q <= s_time;
    end
  end

  sdht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  assign res_index_ext = {{INDEX_W{1'b0}}, res_index};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_outcome_q <= res_outcome;
      out_index_q   <= res_index_ext[INDEX_W-1:0];
      out_count_q   <= res_count;
      out_total_q   <= total_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_total_q, out_count_q, out_index_q, out_outcome_q};

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ({1'b0, idx_q} < used_q))
    else $error("scan index past filled entries");

  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> res_load)
    else $error("entry write without a result");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrites an untaken transfer");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q >= $past(total_q)))
    else $error("total count went down");

endmodule

[sim/seen_device_hit_table_checker.sv]
// Checker for the seen-device hit table: watches both stream channels, keeps
// its own copy of the table to predict each result and compares field by field.
// Depends on sdht_pkg for field widths, outcome codes and the rejected prefixes.
module seen_device_hit_table_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [87:0] s_tdata_i,    // channel[6:0], packet_prefix[54:7], time_ms[86:55]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,    // outcome[1:0], entry_index[5:2],
                                    // entry_count[37:6], total_hits[69:38]
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import sdht_pkg::*;

  typedef struct packed {
    outcome_e             outcome;
    logic [INDEX_W-1:0]   index;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   total;
  } sighting_t;

  // Shadow table
  logic [PREFIX_W-1:0]  key_tab     [TABLE_DEPTH];
  logic [CHANNEL_W-1:0] channel_tab [TABLE_DEPTH];
  logic [TIME_W-1:0]    seen_tab    [TABLE_DEPTH];
  logic [COUNT_W-1:0]   hits_tab    [TABLE_DEPTH];
  int unsigned          fill_level;
  logic [COUNT_W-1:0]   total_seen;

  sighting_t   expected_results [$];
  int unsigned fails;

  // Counters stick at all ones
  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Update the shadow table for one packet and return the result it causes
  function automatic sighting_t predict_sighting(input logic [CHANNEL_W-1:0] ch,
                                                 input logic [PREFIX_W-1:0]  pfx,
                                                 input logic [TIME_W-1:0]    t);
    sighting_t res;
    int        hit;
    hit = -1;
    res.outcome = OUT_REJECT;
    res.index   = '0;
    res.count   = '0;
    if (pfx != PREFIX_ZEROS && pfx != PREFIX_ONES) begin
      // lowest matching entry wins
      for (int i = 0; i < int'(fill_level); i++) begin
        if (hit < 0 && key_tab[i] == pfx) hit = i;
      end
      if (hit >= 0) begin
        channel_tab[hit] = ch;
        seen_tab[hit]    = t;
        hits_tab[hit]    = bump(hits_tab[hit]);
        total_seen       = bump(total_seen);
        res.outcome      = OUT_MATCH;
        res.index        = INDEX_W'(hit);
        res.count        = hits_tab[hit];
      end else if (fill_level < TABLE_DEPTH) begin
        key_tab[fill_level]     = pfx;
        channel_tab[fill_level] = ch;
        seen_tab[fill_level]    = t;
        hits_tab[fill_level]    = 1;
        total_seen              = bump(total_seen);
        res.outcome             = OUT_INSERT;
        res.index               = INDEX_W'(fill_level);
        res.count               = 1;
        fill_level++;
      end else begin
        res.outcome = OUT_DROP;
      end
    end
    res.total = total_seen;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Results are checked before the same edge's packet is predicted
  always @(posedge clk_i) begin
    sighting_t want;
    if (!rst_ni) begin
      // empty shadow table while in reset
      fill_level = 0;
      total_seen = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h", m_tdata_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("outcome", COUNT_W'(want.outcome), COUNT_W'(m_tdata_i[1:0]));
          check_field("entry_index", COUNT_W'(want.index), COUNT_W'(m_tdata_i[5:2]));
          check_field("entry_count", want.count, m_tdata_i[37:6]);
          check_field("total_hits", want.total, m_tdata_i[69:38]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(predict_sighting(s_tdata_i[6:0], s_tdata_i[54:7],
                                                    s_tdata_i[86:55]));
      end
    end
    pending_o    <= expected_results.size();
    fail_count_o <= fails;
  end

endmodule

[sim/seen_device_hit_table_unit_test.sv]
// Testbench top for the seen-device hit table: clock, reset, packet and
// result-side stimulus with random idling, and the final verdict.
// Depends on sdht_pkg, seen_device_hit_table_unit and seen_device_hit_table_checker.
module seen_device_hit_table_unit_test;
  import sdht_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1035;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned KEY_POOL_MAX = 24;
  localparam int unsigned LONG_HOLD    = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // channel[6:0], packet_prefix[54:7], time_ms[86:55]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // outcome[1:0], entry_index[5:2],
                               // entry_count[37:6], total_hits[69:38]

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned gap_odds;
  bit          calm_phase;
  bit          long_hold_done;
  logic [PREFIX_W-1:0] offered_keys [$];

  seen_device_hit_table_unit #(
    .ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  seen_device_hit_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .pending_o   (pending_results),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // Offer one packet, hold it until the transfer, then maybe idle a while
  task automatic send_packet(input logic [CHANNEL_W-1:0] ch,
                             input logic [PREFIX_W-1:0]  pfx,
                             input logic [TIME_W-1:0]    t);
    bit known;
    known = 1'b0;
    s_axis_tdata  <= {1'b0, t, pfx, ch};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    foreach (offered_keys[k]) if (offered_keys[k] == pfx) known = 1'b1;
    if (!known && pfx != PREFIX_ZEROS && pfx != PREFIX_ONES &&
        offered_keys.size() < KEY_POOL_MAX) offered_keys.push_back(pfx);
    if (!calm_phase && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Stop offering until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Result side: random stalls, one long hold-off, none at the end
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm_phase && !long_hold_done && sent_count >= 400) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Packet side
  initial begin
    logic [CHANNEL_W-1:0] ch;
    logic [PREFIX_W-1:0]  pfx;
    logic [TIME_W-1:0]    t;
    int unsigned          roll;
    sent_count     = 0;
    gap_odds       = 3;
    calm_phase     = 1'b0;
    long_hold_done = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejects, field extremes, inserts, hits, near-miss keys
    send_packet(7'd0,   PREFIX_ZEROS,      32'h0000_0000);
    send_packet(7'd125, PREFIX_ONES,       32'hFFFF_FFFF);
    send_packet(7'd0,   48'h0000_0000_0001, 32'h0000_0000);
    send_packet(7'd125, 48'h0000_0000_0001, 32'hFFFF_FFFF);
    send_packet(7'd1,   48'hFFFF_FFFF_FFFE, 32'h0000_0001);
    send_packet(7'd64,  48'h8000_0000_0000, 32'h8000_0000);
    send_packet(7'd63,  48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF);
    send_packet(7'd42,  48'h0000_0000_0001, 32'h1234_5678);
    send_packet(7'd85,  48'h7FFF_FFFF_FFFF, 32'hAAAA_AAAA);
    send_packet(7'd10,  PREFIX_ZEROS,      32'h5555_5555);
    send_packet(7'd20,  48'h1234_5678_9ABC, 32'h0000_0100);
    send_packet(7'd21,  48'h1234_5678_9ABD, 32'h0000_0101);
    send_packet(7'd22,  48'hFFFF_FFFF_FFFE, 32'h0000_0102);
    send_packet(7'd23,  PREFIX_ONES,       32'h0000_0103);
    send_packet(7'd24,  48'h1234_5678_9ABD, 32'h0000_0104);
    drain_results();

    // Random: mostly known keys, some fresh and near-miss keys, a few rejects
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) gap_odds = $urandom_range(0, 3);
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm_phase = 1'b1;
      if (n == 250 || n == 650) drain_results();
      ch   = CHANNEL_W'($urandom_range(0, 125));
      t    = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        pfx = $urandom_range(0, 1) ? PREFIX_ONES : PREFIX_ZEROS;
      end else if (roll < 20 || offered_keys.size() == 0) begin
        pfx = PREFIX_W'({$urandom, $urandom});
      end else if (roll < 32) begin
        pfx = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
        pfx[$urandom_range(0, PREFIX_W - 1)] ^= 1'b1;
      end else begin
        pfx = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
      end
      send_packet(ch, pfx, t);
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/sdht_pkg.sv
src/sdht_ram.sv
src/seen_device_hit_table_unit.sv
sim/seen_device_hit_table_checker.sv
sim/seen_device_hit_table_unit_test.sv
